### rtl/core/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// shared types, constants and helpers for the set-associative cache model
// ----------------------------------------------------------------------------
package sacl_pkg;

    localparam int ADDR_W = 64;
    localparam int CNT_W  = 32;

    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_MAX_WAYS     = 8;

    localparam int SET_BITS_W   = 3;
    localparam int BLOCK_BITS_W = 6;
    localparam int WAYS_W       = 4;
    localparam int CFG_DATA_W   = 6;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 3'd4;
    localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 6'd4;
    localparam logic [WAYS_W-1:0]       WAYS_RST       = 4'd1;

    localparam int FUNC_W = 2;
    localparam logic [FUNC_W-1:0] FUNC_MODIFY = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_INSTR  = 2'd3;

    localparam int IN_TDATA_W  = 64;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_FIELD_W = 2 + 1 + 1 + 3 * CNT_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SET_BITS   = 2'd0,
        REG_BLOCK_BITS = 2'd1,
        REG_WAYS       = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_LOOKUP = 1'b1
    } state_t;

    typedef struct packed {
        logic load;
        logic commit;
    } sacl_cmd_t;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] cnt,
                                                 input logic [1:0] k);
        logic [CNT_W:0] sum;
        sum = {1'b0, cnt} + {{(CNT_W-1){1'b0}}, k};
        return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    endfunction

endpackage

### rtl/core/sacl_ctrl.sv
// ----------------------------------------------------------------------------
// sacl_ctrl
// sequencer: accepts an item, runs the lookup cycle and owns the result valid
// ----------------------------------------------------------------------------
module sacl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output sacl_pkg::sacl_cmd_t cmd
);

    sacl_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sacl_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            sacl_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = sacl_pkg::ST_LOOKUP;
                end
            end
            sacl_pkg::ST_LOOKUP: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.commit = 1'b1;
                    state_next = sacl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sacl_pkg::ST_IDLE;
            end
        endcase
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

    a_load_then_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == sacl_pkg::ST_LOOKUP)
        else $error("load did not move to lookup");

    a_commit_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid)
        else $error("commit did not raise result valid");

    a_commit_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!out_valid_reg || m_tready))
        else $error("commit over an untaken result");

    a_no_accept_in_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sacl_pkg::ST_LOOKUP |-> !s_tready)
        else $error("item accepted during lookup");

endmodule

### rtl/core/sacl_datapath.sv
// ----------------------------------------------------------------------------
// sacl_datapath
// set memory, tag compare, victim choice, recency update and saturating counts
// ----------------------------------------------------------------------------
module sacl_datapath #(
    parameter int MAX_SET_BITS = sacl_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = sacl_pkg::DEF_MAX_WAYS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  sacl_pkg::sacl_cmd_t                   cmd,
    input  logic [sacl_pkg::IN_TDATA_W-1:0]       s_tdata,
    input  logic [sacl_pkg::IN_TUSER_W-1:0]       s_tuser,
    input  logic [sacl_pkg::SET_BITS_W-1:0]       set_bits,
    input  logic [sacl_pkg::BLOCK_BITS_W-1:0]     block_bits,
    input  logic [sacl_pkg::WAYS_W-1:0]           ways,
    output logic [sacl_pkg::OUT_TDATA_W-1:0]      m_tdata
);

    localparam int DEPTH  = 2 ** MAX_SET_BITS;
    localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int AGE_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W = $clog2(MAX_WAYS + 1);
    localparam int AW     = sacl_pkg::ADDR_W;
    localparam int CW     = sacl_pkg::CNT_W;
    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

    // set memory, one row per set
    logic [MAX_WAYS-1:0][AW-1:0]    tag_mem   [DEPTH];
    logic [MAX_WAYS-1:0][AGE_W-1:0] age_mem   [DEPTH];
    logic [MAX_WAYS-1:0]            valid_mem [DEPTH];
    logic [DEPTH-1:0]               row_init_reg;

    logic [sacl_pkg::FUNC_W-1:0]    func_reg;
    logic [AW-1:0]                  tag_reg;
    logic [SET_W-1:0]               set_reg;
    logic [MAX_WAYS-1:0][AW-1:0]    rd_tag_reg;
    logic [MAX_WAYS-1:0][AGE_W-1:0] rd_age_reg;
    logic [MAX_WAYS-1:0]            rd_valid_reg;
    logic                           rd_init_reg;

    logic [CW-1:0] hit_cnt_reg, miss_cnt_reg, evict_cnt_reg;
    logic [CW-1:0] hit_cnt_next, miss_cnt_next, evict_cnt_next;
    logic [1:0]    out_hits_reg;
    logic          out_missed_reg, out_evicted_reg;
    logic [CW-1:0] out_hit_tot_reg, out_miss_tot_reg, out_evict_tot_reg;

    // accept-side address split
    logic [sacl_pkg::SET_BITS_W-1:0] s_eff;
    logic [AW-1:0]                   shifted;
    logic [AW-1:0]                   tag_in;
    logic [SET_W:0]                  mask_wide;
    logic [SET_W-1:0]                set_in;

    always_comb begin
        s_eff     = (int'(set_bits) > MAX_SET_BITS) ?
                    sacl_pkg::SET_BITS_W'(MAX_SET_BITS) : set_bits;
        shifted   = s_tdata[AW-1:0] >> block_bits;
        tag_in    = shifted >> s_eff;
        mask_wide = (SET_W+1)'(1) << s_eff;
        set_in    = shifted[SET_W-1:0] & SET_W'(mask_wide - (SET_W+1)'(1));
    end

    // lookup-side decisions
    logic [WCNT_W-1:0]              n_eff;
    logic [MAX_WAYS-1:0]            use_v, vld;
    logic [MAX_WAYS-1:0][AGE_W-1:0] age;
    logic                           hit, has_empty, is_instr, evict;
    logic [WAY_W-1:0]               hw, ew, vw, w;
    logic [AGE_W-1:0]               best_age;
    logic [AGE_W:0]                 old_age;
    logic [MAX_WAYS-1:0]            nv;
    logic [MAX_WAYS-1:0][AGE_W-1:0] na;
    logic [MAX_WAYS-1:0][AW-1:0]    nt;
    logic [1:0]                     hits;

    always_comb begin
        if (ways == '0) begin
            n_eff = WCNT_W'(1);
        end else if (int'(ways) > MAX_WAYS) begin
            n_eff = WCNT_W'(MAX_WAYS);
        end else begin
            n_eff = WCNT_W'(ways);
        end
        hit       = 1'b0;
        has_empty = 1'b0;
        hw        = '0;
        ew        = '0;
        vw        = '0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            use_v[i] = WCNT_W'(i) < n_eff;
            vld[i]   = rd_init_reg & rd_valid_reg[i];
            age[i]   = rd_init_reg ? rd_age_reg[i] : '0;
        end
        best_age = age[0];
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (!hit && use_v[i] && vld[i] && rd_tag_reg[i] == tag_reg) begin
                hit = 1'b1;
                hw  = WAY_W'(i);
            end
            if (!has_empty && use_v[i] && !vld[i]) begin
                has_empty = 1'b1;
                ew        = WAY_W'(i);
            end
        end
        // lowest way of the oldest age
        for (int i = 1; i < MAX_WAYS; i++) begin
            if (use_v[i] && age[i] > best_age) begin
                best_age = age[i];
                vw       = WAY_W'(i);
            end
        end
        if (hit) begin
            w       = hw;
            old_age = {1'b0, age[hw]};
        end else if (has_empty) begin
            w       = ew;
            old_age = (AGE_W+1)'(MAX_WAYS);
        end else begin
            w       = vw;
            old_age = {1'b0, best_age};
        end
        evict = !hit && !has_empty;
        for (int i = 0; i < MAX_WAYS; i++) begin
            nv[i] = vld[i];
            nt[i] = rd_tag_reg[i];
            na[i] = age[i];
            if (use_v[i] && vld[i] && WAY_W'(i) != w && {1'b0, age[i]} < old_age
                && age[i] < AGE_MAX) begin
                na[i] = age[i] + AGE_W'(1);
            end
        end
        na[w] = '0;
        if (!hit) begin
            nv[w] = 1'b1;
            nt[w] = tag_reg;
        end
        is_instr = func_reg == sacl_pkg::FUNC_INSTR;
        if (is_instr) begin
            hits = 2'd0;
        end else begin
            hits = {1'b0, hit} + {1'b0, func_reg == sacl_pkg::FUNC_MODIFY};
        end
        if (is_instr) begin
            hit_cnt_next   = hit_cnt_reg;
            miss_cnt_next  = miss_cnt_reg;
            evict_cnt_next = evict_cnt_reg;
        end else begin
            hit_cnt_next   = sacl_pkg::sat_add(hit_cnt_reg, hits);
            miss_cnt_next  = sacl_pkg::sat_add(miss_cnt_reg, {1'b0, !hit});
            evict_cnt_next = sacl_pkg::sat_add(evict_cnt_reg, {1'b0, evict});
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rd_tag_reg   <= tag_mem[set_in];
            rd_age_reg   <= age_mem[set_in];
            rd_valid_reg <= valid_mem[set_in];
        end
        if (cmd.commit && !is_instr) begin
            tag_mem[set_reg]   <= nt;
            age_mem[set_reg]   <= na;
            valid_mem[set_reg] <= nv;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_init_reg  <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
        end else if (cmd.commit) begin
            if (!is_instr) begin
                row_init_reg[set_reg] <= 1'b1;
            end
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            evict_cnt_reg <= evict_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg    <= s_tuser[sacl_pkg::FUNC_W-1:0];
            tag_reg     <= tag_in;
            set_reg     <= set_in;
            rd_init_reg <= row_init_reg[set_in];
        end
        if (cmd.commit) begin
            out_hits_reg      <= hits;
            out_missed_reg    <= !is_instr && !hit;
            out_evicted_reg   <= !is_instr && evict;
            out_hit_tot_reg   <= hit_cnt_next;
            out_miss_tot_reg  <= miss_cnt_next;
            out_evict_tot_reg <= evict_cnt_next;
        end
    end

    assign m_tdata = {(sacl_pkg::OUT_TDATA_W - sacl_pkg::OUT_FIELD_W)'(0),
                      out_evict_tot_reg, out_miss_tot_reg, out_hit_tot_reg,
                      out_evicted_reg, out_missed_reg, out_hits_reg};

endmodule

### rtl/core/set_assoc_cache_lru_sim.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim
// set-associative cache with lru replacement, counting hits, misses, evictions
// ----------------------------------------------------------------------------
// One item on the s_ channel is one trace access: the address in s_tdata and
// the access kind in s_tuser. Each item gives exactly one result on the m_
// channel with the per-access flags and the running saturating totals.
// Per item, an accept cycle reads the set row from the set memory and a
// lookup cycle compares tags, picks the victim and writes the row back. No
// item is taken during a lookup. The result is valid from the edge after the
// lookup cycle. A result that is not taken holds in the output register; the
// next item is still accepted and then waits in its lookup cycle until the
// output register is free. Reset clears the counters and one init flag per
// set row, so no clearing pass runs and the block takes items right after
// reset. The user must write configuration through cfg_we / cfg_index /
// cfg_wdata only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_sim #(
    parameter int MAX_SET_BITS = sacl_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = sacl_pkg::DEF_MAX_WAYS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sacl_pkg::IN_TDATA_W-1:0]     s_tdata,  // address[63:0]
    input  logic [sacl_pkg::IN_TUSER_W-1:0]     s_tuser,  // func[1:0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // hits_added[1:0], missed, evicted, hit_total[31:0], miss_total[31:0],
    // eviction_total[31:0], zero pad
    output logic [sacl_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                cfg_we,
    input  logic [sacl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    logic [sacl_pkg::SET_BITS_W-1:0]   set_bits_reg;
    logic [sacl_pkg::BLOCK_BITS_W-1:0] block_bits_reg;
    logic [sacl_pkg::WAYS_W-1:0]       ways_reg;
    sacl_pkg::sacl_cmd_t               cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_bits_reg   <= sacl_pkg::SET_BITS_RST;
            block_bits_reg <= sacl_pkg::BLOCK_BITS_RST;
            ways_reg       <= sacl_pkg::WAYS_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                sacl_pkg::REG_SET_BITS: begin
                    set_bits_reg <= cfg_wdata[sacl_pkg::SET_BITS_W-1:0];
                end
                sacl_pkg::REG_BLOCK_BITS: begin
                    block_bits_reg <= cfg_wdata[sacl_pkg::BLOCK_BITS_W-1:0];
                end
                sacl_pkg::REG_WAYS: begin
                    ways_reg <= cfg_wdata[sacl_pkg::WAYS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    sacl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    sacl_datapath #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .set_bits   (set_bits_reg),
        .block_bits (block_bits_reg),
        .ways       (ways_reg),
        .m_tdata    (m_tdata)
    );

endmodule

### sim/tb_set_assoc_cache_lru_sim.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_lru_sim
// self-checking bench for the set-associative lru cache counter
// ----------------------------------------------------------------------------
// A short table of directed accesses and register writes comes first: reset
// settings, hit and miss on the same block, modify, ignored instruction
// fetches, eviction with one way, duplicate tags and tied ages left behind by
// a change of ways, out-of-range set and way settings and a block offset wide
// enough to leave no tag. Then a series of phases, each with its own register
// settings, sends random accesses built mostly from a small pool of tags and
// sets so that hits, fills and evictions all happen often. A behavioural copy
// of the cache, kept in the bench, predicts every result; each result is
// compared field by field. Both sides of the stream pause at random, with one
// phase free of pauses and one long hold on the result side.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_lru_sim;
    import sacl_pkg::*;

    localparam int SB_CAP    = DEF_MAX_SET_BITS;
    localparam int WAY_CAP   = DEF_MAX_WAYS;
    localparam int LINES     = (1 << SB_CAP) * WAY_CAP;
    localparam int PHASES    = 8;
    localparam int PER_PHASE = 100;
    localparam int HOLD_LEN  = 300;

    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_STORE = 2'd1;

    typedef struct packed {
        logic [CNT_W-1:0] evict_tot;
        logic [CNT_W-1:0] miss_tot;
        logic [CNT_W-1:0] hit_tot;
        logic             evicted;
        logic             missed;
        logic [1:0]       hits;
    } result_t;

    typedef struct {
        bit                is_cfg;
        cfg_reg_t          sel;
        logic [5:0]        value;
        logic [FUNC_W-1:0] fn;
        logic [ADDR_W-1:0] addr;
        bit                typed;
        result_t           want;
    } plan_row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;  // address[63:0]
    logic [IN_TUSER_W-1:0]  s_tuser   = '0;  // func[1:0]
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // hits_added[1:0], missed, evicted, hit_total, miss_total, eviction_total
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // bench copy of the cache
    bit                line_ok  [LINES];
    logic [ADDR_W-1:0] line_tag [LINES];
    logic [2:0]        line_age [LINES];
    logic [CNT_W-1:0]  hit_cnt, miss_cnt, evict_cnt;
    logic [2:0]        cfg_set;
    logic [5:0]        cfg_block;
    logic [3:0]        cfg_ways;

    result_t pending_results[$];
    int      fault_cnt   = 0;
    int      checked_cnt = 0;
    int      sent_cnt    = 0;
    int      ignored_cnt = 0;
    bit      steady      = 1'b0;
    bit      hold_go     = 1'b0;

    set_assoc_cache_lru_sim u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic [CNT_W-1:0] count_up(logic [CNT_W-1:0] c, int unsigned k);
        if (c > {CNT_W{1'b1}} - k) begin
            return {CNT_W{1'b1}};
        end
        return c + k;
    endfunction

    function automatic void promote_line(int unsigned base, int unsigned n, int unsigned w,
                                         int unsigned old_age);
        for (int unsigned i = 0; i < n; i++) begin
            if (i != w && line_ok[base + i] && line_age[base + i] < old_age
                    && line_age[base + i] < WAY_CAP - 1) begin
                line_age[base + i] = line_age[base + i] + 3'd1;
            end
        end
        line_age[base + w] = '0;
    endfunction

    function automatic result_t cache_access(logic [FUNC_W-1:0] fn, logic [ADDR_W-1:0] addr);
        result_t           r;
        int unsigned       s_eff, n_eff, sh, set_idx, base, w;
        logic [ADDR_W-1:0] tg;
        bit                found, empty;
        r = '0;
        s_eff = (cfg_set > SB_CAP) ? SB_CAP : cfg_set;
        n_eff = (cfg_ways == 0) ? 1 : ((cfg_ways > WAY_CAP) ? WAY_CAP : cfg_ways);
        if (fn != FUNC_INSTR) begin
            sh = s_eff + cfg_block;
            tg = (sh >= ADDR_W) ? '0 : (addr >> sh);
            set_idx = 32'((addr >> cfg_block) & ((64'd1 << s_eff) - 64'd1));
            base = set_idx * WAY_CAP;
            w = 0;
            found = 1'b0;
            for (int unsigned i = 0; i < n_eff; i++) begin
                if (!found && line_ok[base + i] && line_tag[base + i] == tg) begin
                    w = i;
                    found = 1'b1;
                end
            end
            if (found) begin
                promote_line(base, n_eff, w, line_age[base + w]);
                r.hits = 2'd1;
            end else begin
                r.missed = 1'b1;
                empty = 1'b0;
                for (int unsigned i = 0; i < n_eff; i++) begin
                    if (!empty && !line_ok[base + i]) begin
                        w = i;
                        empty = 1'b1;
                    end
                end
                if (empty) begin
                    promote_line(base, n_eff, w, WAY_CAP);
                end else begin
                    w = 0;
                    for (int unsigned i = 1; i < n_eff; i++) begin
                        if (line_age[base + i] > line_age[base + w]) begin
                            w = i;
                        end
                    end
                    r.evicted = 1'b1;
                    promote_line(base, n_eff, w, line_age[base + w]);
                end
                line_ok[base + w] = 1'b1;
                line_tag[base + w] = tg;
            end
            if (fn == FUNC_MODIFY) begin
                r.hits = r.hits + 2'd1;
            end
            hit_cnt = count_up(hit_cnt, r.hits);
            miss_cnt = count_up(miss_cnt, r.missed);
            evict_cnt = count_up(evict_cnt, r.evicted);
        end
        r.hit_tot = hit_cnt;
        r.miss_tot = miss_cnt;
        r.evict_tot = evict_cnt;
        return r;
    endfunction

    function automatic plan_row_t row_cfg(cfg_reg_t sel, logic [5:0] v);
        plan_row_t r;
        r = '{is_cfg: 1'b1, sel: sel, value: v, fn: FUNC_LOAD, addr: '0,
              typed: 1'b0, want: '0};
        return r;
    endfunction

    function automatic plan_row_t row_acc(logic [FUNC_W-1:0] fn, logic [ADDR_W-1:0] addr);
        plan_row_t r;
        r = '{is_cfg: 1'b0, sel: REG_SET_BITS, value: '0, fn: fn, addr: addr,
              typed: 1'b0, want: '0};
        return r;
    endfunction

    function automatic plan_row_t row_chk(logic [FUNC_W-1:0] fn, logic [ADDR_W-1:0] addr,
                                          logic [1:0] hits, logic missed, logic evicted,
                                          logic [CNT_W-1:0] h, logic [CNT_W-1:0] m,
                                          logic [CNT_W-1:0] e);
        plan_row_t r;
        r = row_acc(fn, addr);
        r.typed = 1'b1;
        r.want.hits = hits;
        r.want.missed = missed;
        r.want.evicted = evicted;
        r.want.hit_tot = h;
        r.want.miss_tot = m;
        r.want.evict_tot = e;
        return r;
    endfunction

    task automatic push_access(logic [FUNC_W-1:0] fn, logic [ADDR_W-1:0] addr,
                               bit typed, result_t want);
        result_t predicted;
        if (!steady && $urandom_range(0, 99) < 30) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= addr;
        s_tuser  <= fn;
        do @(posedge aclk); while (!s_tready);
        predicted = cache_access(fn, addr);
        pending_results.push_back(typed ? want : predicted);
        sent_cnt++;
        if (fn == FUNC_INSTR) begin
            ignored_cnt++;
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_reg(cfg_reg_t sel, logic [5:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= v;
        @(posedge aclk);
        case (sel)
            REG_SET_BITS:   cfg_set   = v[2:0];
            REG_BLOCK_BITS: cfg_block = v[5:0];
            REG_WAYS:       cfg_ways  = v[3:0];
            default: ;
        endcase
    endtask

    // result side: random back-pressure and one long hold
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_go) begin
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
                hold_go = 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(0, 99) >= 30);
            end
        end
    end

    always @(posedge aclk) begin : check_result
        result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[OUT_FIELD_W-1:0]);
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: %h", m_tdata);
                fault_cnt++;
            end else begin
                want = pending_results.pop_front();
                checked_cnt++;
                if (got.hits !== want.hits) begin
                    $error("hits_added: expected %0d, got %0d", want.hits, got.hits);
                    fault_cnt++;
                end
                if (got.missed !== want.missed) begin
                    $error("missed: expected %0d, got %0d", want.missed, got.missed);
                    fault_cnt++;
                end
                if (got.evicted !== want.evicted) begin
                    $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
                    fault_cnt++;
                end
                if (got.hit_tot !== want.hit_tot) begin
                    $error("hit_total: expected %0d, got %0d", want.hit_tot, got.hit_tot);
                    fault_cnt++;
                end
                if (got.miss_tot !== want.miss_tot) begin
                    $error("miss_total: expected %0d, got %0d", want.miss_tot, got.miss_tot);
                    fault_cnt++;
                end
                if (got.evict_tot !== want.evict_tot) begin
                    $error("eviction_total: expected %0d, got %0d",
                           want.evict_tot, got.evict_tot);
                    fault_cnt++;
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("tb_set_assoc_cache_lru_sim: done, errors");
        $finish;
    end

    initial begin
        plan_row_t         plan[$];
        plan_row_t         row;
        bit                in_cfg;
        logic [ADDR_W-1:0] tag_pool [12];
        logic [ADDR_W-1:0] set_pool [3];
        logic [ADDR_W-1:0] addr, tpart, spart, opart;
        logic [FUNC_W-1:0] fn;
        logic [5:0]        v_set, v_block, v_ways;
        int unsigned       s_eff, sh;
        int                done_cnt;

        for (int i = 0; i < LINES; i++) begin
            line_ok[i] = 1'b0;
            line_tag[i] = '0;
            line_age[i] = '0;
        end
        hit_cnt = '0;
        miss_cnt = '0;
        evict_cnt = '0;
        cfg_set = SET_BITS_RST;
        cfg_block = BLOCK_BITS_RST;
        cfg_ways = WAYS_RST;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        plan = '{
            row_chk(FUNC_LOAD,   64'h0,                  2'd0, 1'b1, 1'b0, 0, 1, 0),
            row_chk(FUNC_LOAD,   64'hF,                  2'd1, 1'b0, 1'b0, 1, 1, 0),
            row_chk(FUNC_MODIFY, 64'h0,                  2'd2, 1'b0, 1'b0, 3, 1, 0),
            row_chk(FUNC_INSTR,  64'hFFFF_FFFF_FFFF_FFFF, 2'd0, 1'b0, 1'b0, 3, 1, 0),
            row_chk(FUNC_STORE,  64'hFFFF_FFFF_FFFF_FFFF, 2'd0, 1'b1, 1'b0, 3, 2, 0),
            row_chk(FUNC_STORE,  64'h100,                2'd0, 1'b1, 1'b1, 3, 3, 1),
            row_chk(FUNC_MODIFY, 64'h0,                  2'd1, 1'b1, 1'b1, 4, 4, 2),
            row_chk(FUNC_INSTR,  64'h0,                  2'd0, 1'b0, 1'b0, 4, 4, 2),
            row_cfg(REG_WAYS, 6'd2),
            row_acc(FUNC_LOAD,   64'h200),
            row_cfg(REG_WAYS, 6'd1),
            row_acc(FUNC_LOAD,   64'h200),
            row_cfg(REG_WAYS, 6'd2),
            row_acc(FUNC_LOAD,   64'h200),
            row_acc(FUNC_STORE,  64'h300),
            row_cfg(REG_WAYS, 6'd0),
            row_acc(FUNC_LOAD,   64'h400),
            row_cfg(REG_WAYS, 6'd15),
            row_cfg(REG_SET_BITS, 6'd7),
            row_cfg(REG_BLOCK_BITS, 6'd0),
            row_acc(FUNC_LOAD,   64'h40),
            row_acc(FUNC_MODIFY, 64'h40),
            row_cfg(REG_BLOCK_BITS, 6'd63),
            row_acc(FUNC_LOAD,   64'h8000_0000_0000_0000),
            row_acc(FUNC_STORE,  64'h7FFF_FFFF_FFFF_FFFF),
            row_cfg(REG_SET_BITS, 6'd0),
            row_acc(FUNC_MODIFY, 64'hDEAD_BEEF_0123_4567)
        };

        in_cfg = 1'b0;
        foreach (plan[i]) begin
            row = plan[i];
            if (row.is_cfg) begin
                if (!in_cfg) begin
                    settle();
                end
                set_reg(row.sel, row.value);
                in_cfg = 1'b1;
            end else begin
                if (in_cfg) begin
                    cfg_we <= 1'b0;
                    in_cfg = 1'b0;
                end
                push_access(row.fn, row.addr, row.typed, row.want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0: begin v_set = 6'd0; v_block = 6'd0;  v_ways = 6'd8;  end
                1: begin v_set = 6'd7; v_block = 6'd63; v_ways = 6'd15; end
                2: begin v_set = 6'd6; v_block = 6'd32; v_ways = 6'd1;  end
                3: begin v_set = 6'd1; v_block = 6'd3;  v_ways = 6'd4;  end
                default: begin
                    v_set = 6'($urandom_range(0, 7));
                    v_block = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                          : 6'($urandom_range(0, 12));
                    v_ways = 6'($urandom_range(0, 15));
                end
            endcase
            set_reg(REG_SET_BITS, v_set);
            set_reg(REG_BLOCK_BITS, v_block);
            set_reg(REG_WAYS, v_ways);
            cfg_we <= 1'b0;

            foreach (tag_pool[k]) tag_pool[k] = {$urandom, $urandom};
            foreach (set_pool[k]) set_pool[k] = {$urandom, $urandom};
            s_eff = (cfg_set > SB_CAP) ? SB_CAP : cfg_set;
            sh = s_eff + cfg_block;
            steady = (ph == 5);
            if (ph == 3) begin
                hold_go = 1'b1;
            end

            done_cnt = 0;
            while (done_cnt < PER_PHASE) begin
                if ($urandom_range(0, 3) != 0) begin
                    tpart = (sh >= ADDR_W) ? '0 : (tag_pool[$urandom_range(0, 11)] << sh);
                    spart = (set_pool[$urandom_range(0, 2)] & ((64'd1 << s_eff) - 64'd1))
                            << cfg_block;
                    opart = {$urandom, $urandom} & ((64'd1 << cfg_block) - 64'd1);
                    addr = tpart | spart | opart;
                end else begin
                    addr = {$urandom, $urandom};
                end
                fn = ($urandom_range(0, 9) == 0) ? FUNC_INSTR
                                                 : FUNC_W'($urandom_range(0, 2));
                push_access(fn, addr, 1'b0, '0);
                if (fn != FUNC_INSTR) begin
                    done_cnt++;
                end
            end
        end

        steady = 1'b0;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("covered %0d accesses (%0d instruction fetches) over %0d register settings",
                 sent_cnt, ignored_cnt, PHASES + 1);
        $display("checked %0d results: %0d hits, %0d misses, %0d evictions",
                 checked_cnt, hit_cnt, miss_cnt, evict_cnt);
        if (fault_cnt == 0) begin
            $display("tb_set_assoc_cache_lru_sim: done, clean");
        end else begin
            $display("tb_set_assoc_cache_lru_sim: done, errors");
        end
        $finish;
    end

endmodule

### set_assoc_cache_lru_sim.f
rtl/core/sacl_pkg.sv
rtl/core/sacl_ctrl.sv
rtl/core/sacl_datapath.sv
rtl/core/set_assoc_cache_lru_sim.sv
sim/tb_set_assoc_cache_lru_sim.sv
